// ===== rtl/gasp_pkg.sv =====
// Shared types, constants, size helper and microcode ROM for the glyph atlas shelf packer.
package gasp_pkg;

	// Field widths
	localparam int SIDE_W           = 13;
	localparam int CUR_W            = 14;
	localparam int FRAC_W           = 17;
	localparam int MAX_ATLAS_SIDE   = 4096;
	localparam int ATLAS_RESET_SIDE = 2048;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'd1;

	// Divider: one integer bit plus one guard bit below the 16 fraction bits
	localparam int DIV_BITS   = FRAC_W + 1;
	localparam int DIV_SUB    = 3;
	localparam int DIV_CYCLES = DIV_BITS / DIV_SUB;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
	localparam int DIV_REM_W  = SIDE_W + 1;

	typedef enum logic [1:0] {
		ST_PLACED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_RESET  = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	// Stay on the current step while the condition holds
	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_NO_IN = 2'd1,
		HOLD_DIV   = 2'd2,
		HOLD_OUT   = 2'd3
	} hold_t;

	typedef enum logic [1:0] {
		BR_NEXT   = 2'd0,
		BR_ALWAYS = 2'd1,
		BR_REJECT = 2'd2
	} br_t;

	// Which texture coordinate the divider works on
	typedef enum logic [1:0] {
		SEL_UL = 2'd0,
		SEL_VT = 2'd1,
		SEL_UR = 2'd2,
		SEL_VB = 2'd3
	} sel_t;

	typedef logic [3:0] upc_t;

	localparam upc_t UA_IDLE   = 4'd0;
	localparam upc_t UA_CHECK  = 4'd1;
	localparam upc_t UA_FIT    = 4'd2;
	localparam upc_t UA_PLACE  = 4'd3;
	localparam upc_t UA_LD_UL  = 4'd4;
	localparam upc_t UA_RUN_UL = 4'd5;
	localparam upc_t UA_ST_UL  = 4'd6;
	localparam upc_t UA_RUN_VT = 4'd7;
	localparam upc_t UA_ST_VT  = 4'd8;
	localparam upc_t UA_RUN_UR = 4'd9;
	localparam upc_t UA_ST_UR  = 4'd10;
	localparam upc_t UA_RUN_VB = 4'd11;
	localparam upc_t UA_ST_VB  = 4'd12;
	localparam upc_t UA_EMIT   = 4'd13;

	typedef struct packed {
		logic  accept;
		logic  do_check;
		logic  do_fit;
		logic  do_place;
		logic  div_start;
		sel_t  ld_sel;
		logic  q_store;
		sel_t  st_sel;
		logic  emit;
		hold_t hold;
		br_t   br;
		upc_t  target;
	} ucw_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic last;
	} div_stat_t;

	// Zero size acts as 1, oversize clamps to the maximum side
	function automatic logic [SIDE_W-1:0] eff_size(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIDE_W'(1);
		else if (int'(v) > MAX_ATLAS_SIDE)
			r = SIDE_W'(MAX_ATLAS_SIDE);
		return r;
	endfunction

	// Microcode program
	function automatic ucw_t ucode_rom(input upc_t a);
		ucw_t w;
		w = '0;
		unique case (a)
			UA_IDLE: begin
				w.accept = 1'b1;
				w.hold   = HOLD_NO_IN;
			end
			UA_CHECK: begin
				w.do_check = 1'b1;
				w.br       = BR_REJECT;
				w.target   = UA_EMIT;
			end
			UA_FIT:   w.do_fit = 1'b1;
			UA_PLACE: w.do_place = 1'b1;
			UA_LD_UL: begin
				w.div_start = 1'b1;
				w.ld_sel    = SEL_UL;
			end
			UA_RUN_UL, UA_RUN_VT, UA_RUN_UR, UA_RUN_VB: w.hold = HOLD_DIV;
			UA_ST_UL: begin
				w.q_store   = 1'b1;
				w.st_sel    = SEL_UL;
				w.div_start = 1'b1;
				w.ld_sel    = SEL_VT;
			end
			UA_ST_VT: begin
				w.q_store   = 1'b1;
				w.st_sel    = SEL_VT;
				w.div_start = 1'b1;
				w.ld_sel    = SEL_UR;
			end
			UA_ST_UR: begin
				w.q_store   = 1'b1;
				w.st_sel    = SEL_UR;
				w.div_start = 1'b1;
				w.ld_sel    = SEL_VB;
			end
			UA_ST_VB: begin
				w.q_store = 1'b1;
				w.st_sel  = SEL_VB;
			end
			UA_EMIT: begin
				w.emit   = 1'b1;
				w.hold   = HOLD_OUT;
				w.br     = BR_ALWAYS;
				w.target = UA_IDLE;
			end
			default: begin
				w.br     = BR_ALWAYS;
				w.target = UA_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/glyph_atlas_shelf_packer.sv =====
// Glyph atlas shelf packer: microcoded sequencer, placement datapath and result register.
//
// Input channel (in_valid / in_stall) carries one glyph size per transaction.
// Output channel (out_valid / out_stall) returns one result per transaction:
// status, top-left placement, four texture coordinates in unsigned 1.16 and the
// current dirty rectangle. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data); index 0 is the atlas width, 1 the atlas height, and any
// write clears the dirty rectangle. Write configuration only while idle.
// A placed glyph passes the check, fit, place and emit steps of the microcode and
// four 1.16 divisions on one shared divider (3 quotient bits per cycle).
// Empty and oversized glyphs branch from the check step straight to emit. One glyph
// is worked at a time, so the next glyph is taken only after the previous one has
// been emitted; in_stall is low only on the idle step, which may be entered while
// the previous result still waits in the output register. When out_stall is high
// while a result is held, that result holds and the sequencer waits on its emit
// step. Reset sets the atlas to 2048 x 2048, clears the cursors and the dirty
// rectangle, and empties the output register.
module glyph_atlas_shelf_packer
	import gasp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIDE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SIDE_W-1:0]    glyph_width,
	input  logic [SIDE_W-1:0]    glyph_height,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [SIDE_W-1:0]    place_x,
	output logic [SIDE_W-1:0]    place_y,
	output logic [FRAC_W-1:0]    u_left,
	output logic [FRAC_W-1:0]    v_top,
	output logic [FRAC_W-1:0]    u_right,
	output logic [FRAC_W-1:0]    v_bottom,
	output logic                 dirty_valid,
	output logic [SIDE_W-1:0]    dirty_left,
	output logic [SIDE_W-1:0]    dirty_top,
	output logic [SIDE_W-1:0]    dirty_right,
	output logic [SIDE_W-1:0]    dirty_bottom
);

	// Sequencer
	upc_t upc_q, upc_nxt;
	ucw_t cw;

	// Configuration and packing state
	logic [SIDE_W-1:0] aw_q, ah_q;
	logic [CUR_W-1:0]  cx_q, cy_q;
	logic [SIDE_W-1:0] rh_q;
	logic              dirty_q;
	logic [SIDE_W-1:0] dl_q, dt_q, dr_q, db_q;

	// Working item
	logic [SIDE_W-1:0] w_q, h_q;
	status_t           st_q;
	logic [SIDE_W-1:0] px_q, py_q;
	logic [FRAC_W-1:0] ul_q, vt_q, ur_q, vb_q;

	// Output register
	logic              out_valid_q;
	status_t           o_st_q;
	logic [SIDE_W-1:0] o_px_q, o_py_q;
	logic [FRAC_W-1:0] o_ul_q, o_vt_q, o_ur_q, o_vb_q;
	logic              o_dv_q;
	logic [SIDE_W-1:0] o_dl_q, o_dt_q, o_dr_q, o_db_q;

	// Combinational datapath
	logic [SIDE_W-1:0] aw_c, ah_c;
	logic              empty_c, over_c, reject_c, wrap_c, fit_c;
	logic [SIDE_W-1:0] px_c, py_c, xe_c, ye_c;
	logic              in_acc, emit_fire, out_busy;

	div_ctl_t          div_ctl;
	div_stat_t         div_stat;
	logic [SIDE_W-1:0] div_num, div_den;
	logic [FRAC_W-1:0] div_quot;

	assign cw = ucode_rom(upc_q);

	assign aw_c     = eff_size(aw_q);
	assign ah_c     = eff_size(ah_q);
	assign empty_c  = (w_q == '0) || (h_q == '0);
	assign over_c   = (w_q > aw_c) || (h_q > ah_c);
	assign reject_c = empty_c || over_c;
	assign wrap_c   = ({1'b0, cx_q} + {2'b0, w_q}) > {2'b0, aw_c};
	assign fit_c    = ({1'b0, cy_q} + {2'b0, h_q}) > {2'b0, ah_c};
	assign px_c     = cx_q[SIDE_W-1:0];
	assign py_c     = cy_q[SIDE_W-1:0];
	assign xe_c     = px_c + w_q;
	assign ye_c     = py_c + h_q;

	assign in_stall  = !cw.accept;
	assign in_acc    = in_valid && cw.accept;
	assign out_busy  = out_valid_q && out_stall;
	assign emit_fire = cw.emit && !out_busy;

	// Step counter: hold, branch or fall through
	always_comb begin
		logic hold_c;
		logic br_c;
		unique case (cw.hold)
			HOLD_NONE:  hold_c = 1'b0;
			HOLD_NO_IN: hold_c = !in_valid;
			HOLD_DIV:   hold_c = div_stat.busy && !div_stat.last;
			HOLD_OUT:   hold_c = out_busy;
			default:    hold_c = 1'b0;
		endcase
		unique case (cw.br)
			BR_NEXT:   br_c = 1'b0;
			BR_ALWAYS: br_c = 1'b1;
			BR_REJECT: br_c = reject_c;
			default:   br_c = 1'b0;
		endcase
		priority if (hold_c)
			upc_nxt = upc_q;
		else if (br_c)
			upc_nxt = cw.target;
		else
			upc_nxt = upc_q + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			upc_q <= UA_IDLE;
		else
			upc_q <= upc_nxt;
	end

	// Divider operand select
	always_comb begin
		unique case (cw.ld_sel)
			SEL_UL: begin div_num = px_q;        div_den = aw_c; end
			SEL_VT: begin div_num = py_q;        div_den = ah_c; end
			SEL_UR: begin div_num = px_q + w_q;  div_den = aw_c; end
			SEL_VB: begin div_num = py_q + h_q;  div_den = ah_c; end
			default: begin div_num = px_q;       div_den = aw_c; end
		endcase
	end

	assign div_ctl.start = cw.div_start;

	gasp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// Atlas size, cursors and dirty rectangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q    <= SIDE_W'(ATLAS_RESET_SIDE);
			ah_q    <= SIDE_W'(ATLAS_RESET_SIDE);
			cx_q    <= '0;
			cy_q    <= '0;
			rh_q    <= '0;
			dirty_q <= 1'b0;
			dl_q    <= '0;
			dt_q    <= '0;
			dr_q    <= '0;
			db_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ATLAS_WIDTH:  aw_q <= cfg_data;
					REG_ATLAS_HEIGHT: ah_q <= cfg_data;
					default: ;
				endcase
				dirty_q <= 1'b0;
				dl_q    <= '0;
				dt_q    <= '0;
				dr_q    <= '0;
				db_q    <= '0;
			end
			// New row when the glyph overruns the current one
			if (cw.do_check && !reject_c && wrap_c) begin
				cx_q <= '0;
				cy_q <= cy_q + {1'b0, rh_q} + CUR_W'(1);
				rh_q <= '0;
			end
			// Atlas full: restart at the origin, whole atlas dirty
			if (cw.do_fit && fit_c) begin
				cx_q    <= '0;
				cy_q    <= '0;
				rh_q    <= '0;
				dirty_q <= 1'b1;
				dl_q    <= '0;
				dt_q    <= '0;
				dr_q    <= aw_c;
				db_q    <= ah_c;
			end
			// Place, grow dirty rectangle, advance cursor
			if (cw.do_place) begin
				if (!dirty_q) begin
					dl_q    <= px_c;
					dt_q    <= py_c;
					dr_q    <= xe_c;
					db_q    <= ye_c;
					dirty_q <= 1'b1;
				end else begin
					if (px_c < dl_q) dl_q <= px_c;
					if (py_c < dt_q) dt_q <= py_c;
					if (xe_c > dr_q) dr_q <= xe_c;
					if (ye_c > db_q) db_q <= ye_c;
				end
				cx_q <= {1'b0, xe_c} + CUR_W'(1);
				if (h_q > rh_q) rh_q <= h_q;
			end
		end
	end

	// Working item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			w_q <= glyph_width;
			h_q <= glyph_height;
		end
		if (cw.do_check) begin
			priority if (empty_c)
				st_q <= ST_EMPTY;
			else if (over_c)
				st_q <= ST_REJECT;
			else
				st_q <= ST_PLACED;
			if (reject_c) begin
				px_q <= '0;
				py_q <= '0;
				ul_q <= '0;
				vt_q <= '0;
				ur_q <= '0;
				vb_q <= '0;
			end
		end
		if (cw.do_fit && fit_c)
			st_q <= ST_RESET;
		if (cw.do_place) begin
			px_q <= px_c;
			py_q <= py_c;
		end
		if (cw.q_store) begin
			unique case (cw.st_sel)
				SEL_UL: ul_q <= div_quot;
				SEL_VT: vt_q <= div_quot;
				SEL_UR: ur_q <= div_quot;
				SEL_VB: vb_q <= div_quot;
				default: ;
			endcase
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			o_st_q <= st_q;
			o_px_q <= px_q;
			o_py_q <= py_q;
			o_ul_q <= ul_q;
			o_vt_q <= vt_q;
			o_ur_q <= ur_q;
			o_vb_q <= vb_q;
			o_dv_q <= dirty_q;
			o_dl_q <= dl_q;
			o_dt_q <= dt_q;
			o_dr_q <= dr_q;
			o_db_q <= db_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = o_st_q;
	assign place_x      = o_px_q;
	assign place_y      = o_py_q;
	assign u_left       = o_ul_q;
	assign v_top        = o_vt_q;
	assign u_right      = o_ur_q;
	assign v_bottom     = o_vb_q;
	assign dirty_valid  = o_dv_q;
	assign dirty_left   = o_dl_q;
	assign dirty_top    = o_dt_q;
	assign dirty_right  = o_dr_q;
	assign dirty_bottom = o_db_q;

`ifndef SYNTHESIS
	// One glyph at a time: input closes right after a transaction
	a_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted on consecutive cycles");

	// Divider is never restarted mid-division
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// Placed glyph: coordinates ordered on both axes
	a_coord_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_PLACED || status == ST_RESET))
		|-> (u_left <= u_right && v_top <= v_bottom))
		else $error("texture coordinates out of order");

	// Tracked dirty rectangle is never inverted
	a_dirty_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dirty_valid)
		|-> (dirty_left <= dirty_right && dirty_top <= dirty_bottom))
		else $error("dirty rectangle inverted");
`endif

endmodule

// ===== rtl/gasp_div.sv =====
// Iterative restoring divider giving floor(num * 65536 / den) for num <= den.
module gasp_div
	import gasp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          ctl,
	input  logic [SIDE_W-1:0] num,
	input  logic [SIDE_W-1:0] den,
	output div_stat_t         stat,
	output logic [FRAC_W-1:0] quot
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_REM_W-1:0] rem_q;
	logic [SIDE_W-1:0]    den_q;
	logic [DIV_BITS-1:0]  q_q;
	logic [DIV_REM_W-1:0] rem_nxt;
	logic [DIV_BITS-1:0]  q_nxt;
	logic                 last_c;

	assign last_c = busy_q && (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));

	// Several compare/subtract steps per cycle, remainder doubled after each
	always_comb begin
		logic [DIV_REM_W-1:0] r;
		logic                 ge;
		r     = rem_q;
		q_nxt = q_q;
		for (int i = 0; i < DIV_SUB; i++) begin
			ge    = (r >= {1'b0, den_q});
			r     = ge ? (r - {1'b0, den_q}) : r;
			q_nxt = {q_nxt[DIV_BITS-2:0], ge};
			r     = {r[DIV_REM_W-2:0], 1'b0};
		end
		rem_nxt = r;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last_c;
			cnt_q  <= cnt_q + DIV_CNT_W'(1);
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			q_q   <= q_nxt;
		end
	end

	// Guard bit dropped: truncation to 1.16
	assign quot      = q_q[DIV_BITS-1:1];
	assign stat.busy = busy_q;
	assign stat.last = last_c;

endmodule
